// ===== design/qcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Quantile curve package
// Shared widths, operation codes, answer kinds and the sequencer state type.
// ----------------------------------------------------------------------------
package qcsr_pkg;

    localparam int VALUE_W = 32;   // Q16.16 point and query values
    localparam int PCT_W   = 20;   // Q3.16 input percentile
    localparam int FRAC_W  = 16;   // fractional bits of a percentile
    localparam int QUO_W   = 17;   // Q0.16 percentile 0..65536
    localparam int CNT_W   = 5;    // holds QUO_W

    localparam logic [QUO_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_RANK   = 2'd2;

    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_PCT   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SMP_LO,
        ST_SMP_HI,
        ST_SMP_MUL,
        ST_SMP_ADD,
        ST_RNK_FIRST,
        ST_RNK_LAST,
        ST_RNK_SCAN,
        ST_RNK_SETUP,
        ST_RNK_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== design/qcsr_div.sv =====
// ----------------------------------------------------------------------------
// Quantile curve serial divider
// Restoring divider producing a 17-bit quotient of (x * 65536) / den, one
// quotient bit per cycle. The caller guarantees the quotient fits 17 bits.
// ----------------------------------------------------------------------------
module qcsr_div
    import qcsr_pkg::*;
#(
    parameter int X_W   = 36,
    parameter int DEN_W = 36
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [X_W-1:0]     x,
    input  logic [DEN_W-1:0]   den,
    output logic               done,
    output logic [QUO_W-1:0]   quotient
);

    logic               busy_reg,  busy_next;
    logic               done_reg,  done_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [DEN_W-1:0]   rem_reg,   rem_next;
    logic [QUO_W-1:0]   low_reg,   low_next;
    logic [DEN_W-1:0]   den_reg,   den_next;
    logic [DEN_W:0]     shifted;
    logic [DEN_W:0]     trial;

    assign shifted = {rem_reg, low_reg[QUO_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        if (start)
        begin
            // The dividend is x followed by 16 zero bits; its top part
            // already lies below den, so 17 steps give the full quotient.
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W);
            rem_next  = DEN_W'(x >> 1);
            low_next  = {x[0], {(QUO_W-1){1'b0}}};
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                rem_next = trial[DEN_W-1:0];
                low_next = {low_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                low_next = {low_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

// ===== design/quantile_curve_sample_and_rank.sv =====
// ----------------------------------------------------------------------------
// Quantile curve sample and rank
// Table of Q16.16 quantile points with linear-interpolation sample and
// inverse rank queries, run by a small sequencer around one table read port.
// ----------------------------------------------------------------------------
// Usage. Each input transaction carries op, point_index, data_value and
// query_percentile. A load (op 0) writes one table point in the cycle it is
// accepted and produces no output; an index at or beyond NUM_POINTS is
// dropped, as is op 3. A sample (op 1) returns a Q16.16 value with
// answer_kind 0; a rank (op 2) returns a Q0.16 percentile with answer_kind 1.
// Queries must only touch points loaded since reset.
// Timing. in_ready is high only while the sequencer is idle. A load leaves
// the sequencer idle. A sample runs from acceptance until its result sits in
// the output register: two table reads, a subtract, a multiply, an add. A rank
// that does not saturate runs a walk over the table that reads one point per
// cycle, set-up of the segment division, and the bit-serial divider.
// Stalls. The result is held in an output register; while it waits for
// out_ready the block still accepts and processes the next transaction, and
// only then waits for the output register to free up.
// Reset. rst_n clears the sequencer and the output valid flag; the table
// contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module quantile_curve_sample_and_rank
    import qcsr_pkg::*;
#(
    parameter int NUM_POINTS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [5:0]                 point_index,
    input  logic signed [VALUE_W-1:0]  data_value,
    input  logic signed [PCT_W-1:0]    query_percentile,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  answer,
    output logic                       answer_kind
);

    localparam int IDX_W = (NUM_POINTS > 2) ? $clog2(NUM_POINTS) : 1;
    localparam int POS_W = QUO_W + IDX_W;
    localparam int X_W   = VALUE_W + IDX_W;
    localparam int PROD_W = VALUE_W + 1 + QUO_W;

    // Table storage with a single registered read port.
    logic [VALUE_W-1:0] mem [NUM_POINTS];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;

    // Sequencer and datapath registers.
    state_t                     state_reg,   state_next;
    logic [IDX_W-1:0]           hi_reg,      hi_next;
    logic [FRAC_W-1:0]          frac_reg,    frac_next;
    logic signed [VALUE_W-1:0]  val_reg,     val_next;
    logic signed [VALUE_W-1:0]  base_reg,    base_next;
    logic signed [VALUE_W:0]    diff_reg,    diff_next;
    logic [VALUE_W-1:0]         dist_reg,    dist_next;
    logic [IDX_W-1:0]           idx_reg,     idx_next;
    logic [IDX_W-1:0]           seg_reg,     seg_next;
    logic signed [PROD_W-1:0]   prod_reg,    prod_next;
    logic [VALUE_W-1:0]         res_reg,     res_next;
    logic                       kind_reg,    kind_next;
    logic                       out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]         answer_reg,  answer_next;
    logic                       answer_kind_reg, answer_kind_next;

    // Combinational helpers.
    logic                       accept;
    logic [QUO_W-1:0]           pct_clamped;
    logic [POS_W-1:0]           pos;
    logic [IDX_W-1:0]           lo_c;
    logic [IDX_W-1:0]           hi_c;
    logic signed [VALUE_W-1:0]  rd_signed;
    logic signed [VALUE_W:0]    sub_c;
    logic                       span_pos;
    logic [VALUE_W-1:0]         span_eff;
    logic [VALUE_W-1:0]         dist_eff;
    logic [X_W-1:0]             div_x;
    logic [X_W-1:0]             div_den;
    logic                       div_start;
    logic                       div_done;
    logic [QUO_W-1:0]           div_quo;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign rd_signed = $signed(rd_data_reg);

    // Sample address: clamp the percentile to [0, 1], scale by the segment
    // count; the integer part picks the lower point, the rest is the fraction.
    always_comb
    begin
        if (query_percentile[PCT_W-1])
        begin
            pct_clamped = '0;
        end
        else if (query_percentile > $signed(PCT_W'(ONE_Q16)))
        begin
            pct_clamped = ONE_Q16;
        end
        else
        begin
            pct_clamped = query_percentile[QUO_W-1:0];
        end
    end

    // The integer part never exceeds NUM_POINTS - 1, so IDX_W bits hold it.
    assign pos  = POS_W'(pct_clamped) * POS_W'(NUM_POINTS - 1);
    assign lo_c = pos[FRAC_W +: IDX_W];
    assign hi_c = (lo_c == IDX_W'(NUM_POINTS - 1)) ? lo_c : lo_c + 1'b1;

    // One subtractor serves both the sample difference and the rank span:
    // base_reg holds the lower point in either case.
    assign sub_c = {rd_signed[VALUE_W-1], rd_signed} - {base_reg[VALUE_W-1], base_reg};

    // A flat or falling segment contributes no in-segment fraction; running
    // it as span 1, distance 0 gives the same floor((i-1)*65536/(N-1)) result.
    assign span_pos = !diff_reg[VALUE_W] && (diff_reg != '0);
    assign span_eff = span_pos ? diff_reg[VALUE_W-1:0] : VALUE_W'(1);
    assign dist_eff = span_pos ? dist_reg : '0;
    assign div_x    = X_W'(seg_reg) * X_W'(span_eff) + X_W'(dist_eff);
    assign div_den  = X_W'(span_eff) * X_W'(NUM_POINTS - 1);
    assign div_start = (state_reg == ST_RNK_SETUP);

    qcsr_div #(
        .X_W   (X_W),
        .DEN_W (X_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .x        (div_x),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Loads write straight from the input transaction.
    assign wr_en = accept && (op == OP_LOAD) && ({1'b0, point_index} < 7'(NUM_POINTS));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[point_index[IDX_W-1:0]] <= data_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer: next state, read address and datapath updates.
    always_comb
    begin
        state_next       = state_reg;
        hi_next          = hi_reg;
        frac_next        = frac_reg;
        val_next         = val_reg;
        base_next        = base_reg;
        diff_next        = diff_reg;
        dist_next        = dist_reg;
        idx_next         = idx_reg;
        seg_next         = seg_reg;
        prod_next        = prod_reg;
        res_next         = res_reg;
        kind_next        = kind_reg;
        out_valid_next   = out_valid_reg;
        answer_next      = answer_reg;
        answer_kind_next = answer_kind_reg;
        rd_addr          = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = (op == OP_SAMPLE) ? lo_c : '0;
                if (accept)
                begin
                    val_next  = data_value;
                    hi_next   = hi_c;
                    frac_next = pos[FRAC_W-1:0];
                    case (op)
                        OP_SAMPLE: state_next = ST_SMP_LO;
                        OP_RANK:   state_next = ST_RNK_FIRST;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end

            ST_SMP_LO:
            begin
                base_next  = rd_signed;
                rd_addr    = hi_reg;
                state_next = ST_SMP_HI;
            end

            ST_SMP_HI:
            begin
                diff_next  = sub_c;
                state_next = ST_SMP_MUL;
            end

            ST_SMP_MUL:
            begin
                prod_next  = diff_reg * $signed({1'b0, frac_reg});
                state_next = ST_SMP_ADD;
            end

            ST_SMP_ADD:
            begin
                // Arithmetic shift by 16 floors toward minus infinity.
                res_next   = base_reg + prod_reg[FRAC_W +: VALUE_W];
                kind_next  = KIND_VALUE;
                state_next = ST_DONE;
            end

            ST_RNK_FIRST:
            begin
                base_next = rd_signed;
                rd_addr   = IDX_W'(NUM_POINTS - 1);
                if (val_reg <= rd_signed)
                begin
                    res_next   = '0;
                    kind_next  = KIND_PCT;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RNK_LAST;
                end
            end

            ST_RNK_LAST:
            begin
                rd_addr  = IDX_W'(1);
                idx_next = IDX_W'(1);
                if (val_reg >= rd_signed)
                begin
                    res_next   = VALUE_W'(ONE_Q16);
                    kind_next  = KIND_PCT;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RNK_SCAN;
                end
            end

            ST_RNK_SCAN:
            begin
                // The last point is above the value, so the walk always stops.
                if (val_reg <= rd_signed)
                begin
                    diff_next  = sub_c;
                    dist_next  = VALUE_W'(val_reg - base_reg);
                    seg_next   = idx_reg - 1'b1;
                    state_next = ST_RNK_SETUP;
                end
                else
                begin
                    base_next = rd_signed;
                    idx_next  = idx_reg + 1'b1;
                    rd_addr   = idx_reg + 1'b1;
                end
            end

            ST_RNK_SETUP:
            begin
                state_next = ST_RNK_DIV;
            end

            ST_RNK_DIV:
            begin
                if (div_done)
                begin
                    res_next   = VALUE_W'(div_quo);
                    kind_next  = KIND_PCT;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    answer_next      = res_reg;
                    answer_kind_next = kind_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg          <= hi_next;
        frac_reg        <= frac_next;
        val_reg         <= val_next;
        base_reg        <= base_next;
        diff_reg        <= diff_next;
        dist_reg        <= dist_next;
        idx_reg         <= idx_next;
        seg_reg         <= seg_next;
        prod_reg        <= prod_next;
        res_reg         <= res_next;
        kind_reg        <= kind_next;
        answer_reg      <= answer_next;
        answer_kind_reg <= answer_kind_next;
    end

    assign out_valid   = out_valid_reg;
    assign answer      = $signed(answer_reg);
    assign answer_kind = answer_kind_reg;

endmodule

// ===== test/quantile_curve_sample_and_rank_test.sv =====
// ----------------------------------------------------------------------------
// Quantile curve sample and rank testbench
// Loads quantile tables into the block and checks every sample and rank
// answer against an in-bench predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module quantile_curve_sample_and_rank_test
    import qcsr_pkg::*;
();

    localparam int NUM_POINTS    = 16;
    localparam int HALF_PERIOD   = 4;
    // The slowest correct run is about 1400 transactions, each paying a long
    // sender gap, a full rank and a long receiver stall. This limit is
    // several times that.
    localparam int CYCLE_LIMIT   = 1000000;
    // At the end, wait somewhat longer than the slowest rank takes.
    localparam int SETTLE_CYCLES = 64;

    // The fourth opcode has no meaning and must be dropped by the block.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam longint VALUE_MIN = -64'sd2147483648;
    localparam longint VALUE_MAX = 64'sd2147483647;
    localparam longint UNIT_PCT  = 64'sd65536;   // 1.0 in Q0.16

    typedef struct packed {
        logic signed [VALUE_W-1:0] answer;
        logic                      kind;
    } curve_answer_t;

    // Block ports. Every input holds a known value from time zero.
    logic                       clk              = 1'b0;
    logic                       rst_n            = 1'b0;
    logic                       in_valid         = 1'b0;
    logic                       in_ready;
    logic [1:0]                 op               = OP_LOAD;
    logic [5:0]                 point_index      = '0;
    logic signed [VALUE_W-1:0]  data_value       = '0;
    logic signed [PCT_W-1:0]    query_percentile = '0;
    logic                       out_valid;
    logic                       out_ready        = 1'b0;
    logic signed [VALUE_W-1:0]  answer;
    logic                       answer_kind;

    // Predictor state: the table as the block should hold it, and the answers
    // still owed by the block, oldest first.
    logic signed [VALUE_W-1:0]  curve_table [NUM_POINTS];
    curve_answer_t              expected_answers [$];
    curve_answer_t              oldest_answer;

    int failures    = 0;
    int cycle_count = 0;
    int ready_hold  = 0;
    // While set, neither side idles, which gives back-to-back stretches.
    bit calm        = 1'b0;

    quantile_curve_sample_and_rank #(
        .NUM_POINTS       (NUM_POINTS)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .point_index      (point_index),
        .data_value       (data_value),
        .query_percentile (query_percentile),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .answer           (answer),
        .answer_kind      (answer_kind)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Sample: clamp the percentile to [0, 1], scale it onto the point index
    // range and interpolate between the two neighboring points. The fraction
    // is applied with rounding toward minus infinity.
    function automatic logic signed [VALUE_W-1:0] interpolate_sample(
        input logic signed [PCT_W-1:0] pct
    );
        longint p;
        longint pos;
        longint lo;
        longint hi;
        longint frac;
        longint diff;
        p = pct;
        if (p < 0)
            p = 0;
        else if (p > UNIT_PCT)
            p = UNIT_PCT;
        pos  = p * (NUM_POINTS - 1);
        lo   = pos / UNIT_PCT;
        frac = pos % UNIT_PCT;
        hi   = (lo + 1 > NUM_POINTS - 1) ? NUM_POINTS - 1 : lo + 1;
        diff = longint'(curve_table[hi]) - longint'(curve_table[lo]);
        // An arithmetic shift is the floor, also on a falling segment.
        return VALUE_W'(longint'(curve_table[lo]) + ((diff * frac) >>> 16));
    endfunction

    // Rank: the inverse of sample. Values at or past either end of the table
    // saturate; otherwise the first point not below the value closes the
    // segment, and the position within it is divided out with truncation.
    function automatic logic signed [VALUE_W-1:0] rank_of_value(
        input logic signed [VALUE_W-1:0] v
    );
        longint lv;
        longint span;
        longint num;
        lv = v;
        if (lv <= curve_table[0])
            return '0;
        if (lv >= curve_table[NUM_POINTS-1])
            return VALUE_W'(UNIT_PCT);
        for (int i = 1; i < NUM_POINTS; i++)
        begin
            if (lv <= curve_table[i])
            begin
                span = longint'(curve_table[i]) - longint'(curve_table[i-1]);
                // A flat or falling segment contributes no fraction.
                if (span <= 0)
                    return VALUE_W'((i - 1) * UNIT_PCT / (NUM_POINTS - 1));
                num = ((i - 1) * span + (lv - curve_table[i-1])) * UNIT_PCT;
                return VALUE_W'(num / (span * (NUM_POINTS - 1)));
            end
        end
        // The loop always returns by the last point, so this line is never reached.
        return VALUE_W'(UNIT_PCT);
    endfunction

    // Appends one answer to the end of the owed list.
    function automatic void owe_answer(input curve_answer_t a);
        expected_answers = {expected_answers, a};
    endfunction

    // Applies one accepted transaction: a load updates the table, a query
    // queues the answer the block owes. Dropped transactions change nothing.
    function automatic void predict_curve_response(
        input logic [1:0]                f_op,
        input logic [5:0]                f_slot,
        input logic signed [VALUE_W-1:0] f_value,
        input logic signed [PCT_W-1:0]   f_pct
    );
        case (f_op)
            OP_LOAD:
                if (f_slot < NUM_POINTS)
                    curve_table[f_slot] = f_value;
            OP_SAMPLE:
                owe_answer(curve_answer_t'{interpolate_sample(f_pct), KIND_VALUE});
            OP_RANK:
                owe_answer(curve_answer_t'{rank_of_value(f_value), KIND_PCT});
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Presents one transaction and returns in the time step of its acceptance.
    // Valid is left high, so the next call either lowers it for a gap or
    // replaces the payload before the following edge.
    task automatic send_item(
        input logic [1:0]                f_op,
        input logic [5:0]                f_slot,
        input logic signed [VALUE_W-1:0] f_value,
        input logic signed [PCT_W-1:0]   f_pct
    );
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        op               <= f_op;
        point_index      <= f_slot;
        data_value       <= f_value;
        query_percentile <= f_pct;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_curve_response(f_op, f_slot, f_value, f_pct);
    endtask

    // Stops sending and holds off until every owed answer has come back.
    // At least one edge passes, so valid never gets two updates in one step.
    task automatic wait_for_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] to_value(input longint x);
        if (x < VALUE_MIN)
            return VALUE_W'(VALUE_MIN);
        if (x > VALUE_MAX)
            return VALUE_W'(VALUE_MAX);
        return VALUE_W'(x);
    endfunction

    // A transaction the block must drop: the unused opcode or a load past the
    // end of the table. Either one carries random content.
    task automatic send_stray_item();
        if ($urandom_range(0, 1) == 0)
            send_item(OP_UNUSED, 6'($urandom), $signed($urandom), PCT_W'($urandom));
        else
            send_item(OP_LOAD, 6'($urandom_range(NUM_POINTS, 63)), $signed($urandom),
                      PCT_W'($urandom));
    endtask

    // Writes all points of a table, in slot order or shuffled, with a few
    // dropped transactions mixed in.
    task automatic load_curve(
        input logic signed [VALUE_W-1:0] pts [NUM_POINTS],
        input bit                        in_order
    );
        int order [NUM_POINTS];
        int k;
        int j;
        int swap;
        for (k = 0; k < NUM_POINTS; k++)
            order[k] = k;
        if (!in_order)
        begin
            for (k = NUM_POINTS - 1; k > 0; k--)
            begin
                j        = $urandom_range(0, k);
                swap     = order[k];
                order[k] = order[j];
                order[j] = swap;
            end
        end
        for (k = 0; k < NUM_POINTS; k++)
        begin
            send_item(OP_LOAD, 6'(order[k]), pts[order[k]], PCT_W'($urandom));
            if ($urandom_range(0, 9) == 0)
                send_stray_item();
        end
    endtask

    // A mix of sample and rank queries aimed at the current table. Samples
    // mostly fall inside [0, 1], some right beside a point, some far outside.
    // Ranks mostly land on or next to a point or inside the table's range.
    task automatic run_queries(input int count);
        longint                  lo_end;
        longint                  hi_end;
        longint                  pick;
        logic signed [PCT_W-1:0] pct;
        int                      roll;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 45)
            begin
                roll = $urandom_range(0, 9);
                if (roll < 6)
                    pct = PCT_W'($urandom_range(0, 65536));
                else if (roll < 8)
                    pct = PCT_W'(($urandom_range(0, NUM_POINTS - 1) * 65536
                                  + $urandom_range(0, NUM_POINTS - 2)) / (NUM_POINTS - 1));
                else if (roll < 9)
                    pct = PCT_W'($urandom);
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       pct = {1'b1, {(PCT_W-1){1'b0}}};
                        1:       pct = {1'b0, {(PCT_W-1){1'b1}}};
                        2:       pct = '0;
                        default: pct = PCT_W'(UNIT_PCT);
                    endcase
                end
                send_item(OP_SAMPLE, 6'($urandom), $signed($urandom), pct);
            end
            else
            begin
                lo_end = curve_table[0];
                hi_end = curve_table[NUM_POINTS-1];
                roll   = $urandom_range(0, 9);
                if (roll < 4)
                    pick = longint'(curve_table[$urandom_range(0, NUM_POINTS - 1)])
                           + int'($urandom_range(0, 4)) - 2;
                else if (roll < 7 && hi_end > lo_end)
                    pick = lo_end + longint'({$urandom, $urandom} % (hi_end - lo_end + 1));
                else if (roll < 9)
                    pick = longint'($signed($urandom));
                else
                    pick = ($urandom_range(0, 1) == 0) ? VALUE_MIN : VALUE_MAX;
                send_item(OP_RANK, 6'($urandom), to_value(pick), PCT_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A fixed table that spans the whole value range and has a flat segment,
    // followed by a load past the end of the table and the unused opcode.
    // The queries after it show that neither touched the table.
    task automatic test_curve_load_and_ignored();
        logic signed [VALUE_W-1:0] point;
        int k;
        for (k = 0; k < NUM_POINTS; k++)
        begin
            if (k == 0)
                point = VALUE_W'(VALUE_MIN);
            else if (k <= 2)
                point = VALUE_W'(-64'sd65536000);
            else if (k == NUM_POINTS - 1)
                point = VALUE_W'(VALUE_MAX);
            else
                point = VALUE_W'(longint'(k - 8) * 1048576 + k);
            send_item(OP_LOAD, 6'(k), point, '0);
        end
        send_item(OP_LOAD, 6'd63, '0, '1);
        send_item(OP_UNUSED, 6'd0, VALUE_W'(VALUE_MAX), '0);
    endtask

    // Percentiles below zero and above one clamp; one index step short of the
    // second point interpolates across the wide first segment.
    task automatic test_sample_extremes();
        send_item(OP_SAMPLE, 6'd0,  VALUE_W'(VALUE_MIN), {1'b1, {(PCT_W-1){1'b0}}});
        send_item(OP_SAMPLE, 6'd63, VALUE_W'(VALUE_MAX), '0);
        send_item(OP_SAMPLE, 6'd0,  '0, PCT_W'(4369));
        send_item(OP_SAMPLE, 6'd0,  '0, PCT_W'(UNIT_PCT));
        send_item(OP_SAMPLE, 6'd0,  '0, {1'b0, {(PCT_W-1){1'b1}}});
    endtask

    // Ranks at both ends of the value range, just inside each end, on the
    // flat segment's level and exactly on an inner point.
    task automatic test_rank_extremes();
        send_item(OP_RANK, 6'd0, VALUE_W'(VALUE_MIN), '0);
        send_item(OP_RANK, 6'd0, VALUE_W'(VALUE_MIN + 1), '0);
        send_item(OP_RANK, 6'd0, curve_table[2], '0);
        send_item(OP_RANK, 6'd0, curve_table[7], '0);
        send_item(OP_RANK, 6'd0, VALUE_W'(VALUE_MAX - 1), '0);
        send_item(OP_RANK, 6'd0, VALUE_W'(VALUE_MAX), '1);
    endtask

    // The sender pauses until the block has delivered everything, then
    // starts again from an idle block.
    task automatic test_pause_until_drained();
        send_item(OP_RANK, 6'd1, to_value(longint'(curve_table[9]) + 3), '0);
        send_item(OP_SAMPLE, 6'd2, '0, PCT_W'(30000));
        wait_for_answers();
        send_item(OP_RANK, 6'd3, to_value(longint'(curve_table[12]) - 1), '0);
        wait_for_answers();
    endtask

    // Well-formed tables: nondecreasing points with random starting level and
    // steps of every size, flat runs included, sometimes saturating at the
    // top. Each table is followed by a batch of queries.
    task automatic test_random_curves(input int rounds);
        logic signed [VALUE_W-1:0] pts [NUM_POINTS];
        longint level;
        int     k;
        repeat (rounds)
        begin
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0:       level = VALUE_MIN;
                1:       level = VALUE_MAX - longint'($urandom_range(0, 1 << 24));
                2:       level = longint'($signed($urandom));
                default: level = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            endcase
            for (k = 0; k < NUM_POINTS; k++)
            begin
                pts[k] = to_value(level);
                case ($urandom_range(0, 5))
                    0:       level += 0;
                    1:       level += $urandom_range(1, 255);
                    2:       level += $urandom_range(1, 65536);
                    3:       level += $urandom_range(1, 1 << 22);
                    4:       level += longint'($urandom) >> $urandom_range(4, 12);
                    default: level += $urandom_range(0, 1 << 26);
                endcase
            end
            if ($urandom_range(0, 5) == 0)
                pts[NUM_POINTS-1] = VALUE_W'(VALUE_MAX);
            load_curve(pts, 1'($urandom_range(0, 1)));
            run_queries(20);
            if ($urandom_range(0, 3) == 0)
                wait_for_answers();
        end
    endtask

    // Tables of arbitrary points, not monotonic, with single points rewritten
    // between queries so the segment search meets every kind of ordering.
    task automatic test_scrambled_curves(input int rounds);
        logic signed [VALUE_W-1:0] pts [NUM_POINTS];
        int k;
        repeat (rounds)
        begin
            calm = ($urandom_range(0, 4) == 0);
            for (k = 0; k < NUM_POINTS; k++)
                pts[k] = $signed($urandom);
            load_curve(pts, 1'b0);
            repeat (5)
            begin
                send_item(OP_LOAD, 6'($urandom_range(0, NUM_POINTS - 1)), $signed($urandom),
                          PCT_W'($urandom));
                run_queries(4);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // The receiver stalls for random stretches; a zero-length stall leaves
    // out_ready high, so long runs without stalls occur as well.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= idle_cycles();
        end
    end

    // Every result transaction is compared with the oldest owed answer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("answer: no result expected, actual %0d (answer_kind %0d)",
                       answer, answer_kind);
                failures++;
            end
            else
            begin
                oldest_answer = expected_answers.pop_front();
                if (answer !== oldest_answer.answer)
                begin
                    $error("answer: expected %0d, actual %0d", oldest_answer.answer, answer);
                    failures++;
                end
                if (answer_kind !== oldest_answer.kind)
                begin
                    $error("answer_kind: expected %0d, actual %0d",
                           oldest_answer.kind, answer_kind);
                    failures++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("quantile_curve_sample_and_rank_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    // Reset is held from time zero and released once. The directed tests run
    // first and leave every table slot written, so no later query can read
    // a point that was never loaded.
    initial
    begin : run_tests
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_curve_load_and_ignored();
        test_sample_extremes();
        test_rank_extremes();
        test_pause_until_drained();
        test_random_curves(28);
        test_scrambled_curves(6);
        wait_for_answers();
        // Nothing is owed any more; any further result would be a stray one.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("quantile_curve_sample_and_rank_test OK");
        else
            $display("quantile_curve_sample_and_rank_test NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/qcsr_pkg.sv
design/qcsr_div.sv
design/quantile_curve_sample_and_rank.sv
test/quantile_curve_sample_and_rank_test.sv
